>>> hw/rtl/evm_pkg.sv
// Shared types, constants and helper functions for the elliptical vignette mask.
// No dependencies.
package evm_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int QW          = 16;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int NUM_W       = 30;
  localparam int DEN_W       = 17;
  localparam int ROOT_W      = 16;
  localparam int DIV_LAT     = QW + 1;
  localparam int SQRT_LAT    = ROOT_W + 1;
  localparam int FRONT_LAT   = 1 + DIV_LAT;
  localparam int BACK_LAT    = 9 + DIV_LAT + SQRT_LAT;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_DUAL_MODE,
    REG_IMAGE_SIZE,
    REG_E1_CENTER,
    REG_E1_RADIUS,
    REG_E2_CENTER,
    REG_E2_RADIUS,
    REG_LEVELS
  } cfg_reg_e;

  typedef struct packed {
    logic signed [QW-1:0] ny;
    logic signed [QW-1:0] nx;
  } pos_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [16:0] abs18(input logic signed [17:0] v);
    logic signed [17:0] n;
    n = -v;
    return v[17] ? n[16:0] : v[16:0];
  endfunction

  function automatic logic [NUM_W-1:0] div_num(input logic [16:0] mag,
                                               input logic [DEN_W-1:0] den);
    return (NUM_W'(mag) << FRAC_BITS) + NUM_W'(den >> 1);
  endfunction

  function automatic logic signed [QW-1:0] sat_sub(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] d;
    d = {a[QW-1], a} - {b[QW-1], b};
    if (d > $signed({2'b00, {(QW-1){1'b1}}})) return {1'b0, {(QW-1){1'b1}}};
    if (d < $signed({2'b11, {(QW-1){1'b0}}})) return {1'b1, {(QW-1){1'b0}}};
    return d[QW-1:0];
  endfunction

  function automatic logic rad_ok(input logic [31:0] r);
    return !r[15] && (r[15:0] != '0) && !r[31] && (r[31:16] != '0);
  endfunction

endpackage

>>> hw/rtl/elliptical_vignette_mask.sv
// Throughput one pixel per cycle when neither pipe is stalled.
// Stalls: the front divider pipe holds when the four-entry queue is full, the back pipe
// holds while the output word waits. Pipeline depth is set by the bit-per-stage dividers
// and square root. Reset clears control state and loads register defaults; no clearing pass.
// Top level: configuration registers, front end, queue and back end. Depends on evm_pkg.
module elliptical_vignette_mask import evm_pkg::*; #(
  parameter int MAX_DIM = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // row[13:0], col[27:14], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // mask_value[12:0], zero pad
  output logic        m_axis_tuser    // valid_res
);

  logic        dual_q;
  logic [30:0] size_q;
  logic [31:0] c1_q, r1_q, c2_q, r2_q;
  logic [47:0] levels_q;
  logic        ok;
  logic        push, pop;
  pos_t        push_pos, head_pos;
  q_stat_t     q_stat;
  logic [12:0] mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dual_q   <= 1'b0;
      size_q   <= 31'd67109888;
      c1_q     <= '0;
      r1_q     <= 32'd268439552;
      c2_q     <= '0;
      r2_q     <= 32'd268439552;
      levels_q <= 48'd4096;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DUAL_MODE:  dual_q   <= cfg_data_i[0];
        REG_IMAGE_SIZE: size_q   <= cfg_data_i[30:0];
        REG_E1_CENTER:  c1_q     <= cfg_data_i[31:0];
        REG_E1_RADIUS:  r1_q     <= cfg_data_i[31:0];
        REG_E2_CENTER:  c2_q     <= cfg_data_i[31:0];
        REG_E2_RADIUS:  r2_q     <= cfg_data_i[31:0];
        REG_LEVELS:     levels_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ok = (size_q[15:0] != '0) && (size_q[30:16] != '0) && rad_ok(r1_q)
              && (!dual_q || rad_ok(r2_q));

  evm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .row_i      (s_axis_tdata[13:0]),
    .col_i      (s_axis_tdata[27:14]),
    .full_i     (q_stat.full),
    .push_o     (push),
    .pos_o      (push_pos)
  );

  evm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_pos),
    .pop_i  (pop),
    .data_o (head_pos),
    .stat_o (q_stat)
  );

  evm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dual_i      (dual_q),
    .c1_i        (c1_q),
    .r1_i        (r1_q),
    .c2_i        (c2_q),
    .r2_i        (r2_q),
    .levels_i    (levels_q),
    .ok_i        (ok),
    .q_stat_i    (q_stat),
    .head_i      (head_pos),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .mask_o      (mask),
    .res_valid_o (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, mask};

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[12:0] == 13'd0)
    else $error("invalid result carries a non-zero mask");

  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[12:0] <= 13'd4096)
    else $error("mask above 1.0");

  a_valid_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> rad_ok(r1_q))
    else $error("valid result with non-positive radius");

  a_queue_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !push)
    else $error("queue written while full");

endmodule

>>> hw/rtl/evm_div.sv
// Pipelined restoring divider, one quotient bit per stage, rounded and saturated to Q4.12.
// Depends on evm_pkg.
module evm_div import evm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 neg_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [DEN_W-1:0]     den_i,
  output logic signed [QW-1:0] quo_o
);

  localparam int QB = DIV_LAT - 1;
  localparam int CW = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1;
  localparam logic [QB:0] POS_MAX = (QB+1)'((1 << (QW - 1)) - 1);
  localparam logic [QB:0] NEG_MAX = (QB+1)'(1 << (QW - 1));

  logic [CW-1:0]    rem_q [QB+1];
  logic [DEN_W-1:0] den_q [QB+1];
  logic             neg_q [QB+1];
  logic             ovf_q [QB+1];
  logic [QB-1:0]    quo_q [QB+1];
  logic [QB:0]      mag;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= CW'(num_i);
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= CW'(num_i) >= (CW'(den_i) << QB);
      quo_q[0] <= '0;
      for (int k = 1; k <= QB; k++) begin
        if (rem_q[k-1] >= (CW'(den_q[k-1]) << (QB - k))) begin
          rem_q[k] <= rem_q[k-1] - (CW'(den_q[k-1]) << (QB - k));
          quo_q[k] <= quo_q[k-1] | (QB'(1) << (QB - k));
        end else begin
          rem_q[k] <= rem_q[k-1];
          quo_q[k] <= quo_q[k-1];
        end
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  always_comb begin
    mag = {ovf_q[QB], quo_q[QB]};
    if (!neg_q[QB]) begin
      quo_o = (mag > POS_MAX) ? QW'(POS_MAX) : QW'(mag);
    end else begin
      quo_o = (mag > NEG_MAX) ? QW'(NEG_MAX) : -QW'(mag);
    end
  end

endmodule

>>> hw/rtl/evm_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage, rounded to nearest.
// Depends on evm_pkg.
module evm_sqrt import evm_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2*ROOT_W-1:0] val_i,
  output logic [ROOT_W-1:0]   root_o
);

  localparam int RMW = 2 * ROOT_W + 1;

  logic [RMW-1:0]    rem_q [ROOT_W+1];
  logic [ROOT_W-1:0] res_q [ROOT_W+1];
  logic [RMW-1:0]    trial [ROOT_W+1];

  always_comb begin
    trial[0] = '0;
    for (int k = 1; k <= ROOT_W; k++) begin
      trial[k] = (RMW'(res_q[k-1]) << (ROOT_W - k + 1)) + (RMW'(1) << (2 * (ROOT_W - k)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RMW'(val_i);
      res_q[0] <= '0;
      for (int k = 1; k <= ROOT_W; k++) begin
        if (rem_q[k-1] >= trial[k]) begin
          rem_q[k] <= rem_q[k-1] - trial[k];
          res_q[k] <= res_q[k-1] | (ROOT_W'(1) << (ROOT_W - k));
        end else begin
          rem_q[k] <= rem_q[k-1];
          res_q[k] <= res_q[k-1];
        end
      end
    end
  end

  assign root_o = (rem_q[ROOT_W] > RMW'(res_q[ROOT_W])) ? res_q[ROOT_W] + 1'b1
                                                        : res_q[ROOT_W];

endmodule

>>> hw/rtl/evm_front.sv
// Front end: accepts pixel positions and normalises them to Q4.12 around the image centre.
// Depends on evm_pkg and evm_div.
module evm_front import evm_pkg::*; #(
  parameter int MAX_DIM = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [30:0] size_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [13:0] row_i,
  input  logic [13:0] col_i,
  input  logic        full_i,
  output logic        push_o,
  output pos_t        pos_o
);

  logic [FRONT_LAT-1:0] vld_q;
  logic [13:0]          row_q, col_q;
  logic                 en;
  logic [DEN_W-1:0]     w, h;
  logic signed [17:0]   sx, sy;

  assign w = (DEN_W'(size_i[15:0]) > DEN_W'(MAX_DIM)) ? DEN_W'(MAX_DIM) : DEN_W'(size_i[15:0]);
  assign h = (DEN_W'(size_i[30:16]) > DEN_W'(MAX_DIM)) ? DEN_W'(MAX_DIM)
                                                       : DEN_W'(size_i[30:16]);

  assign en         = !vld_q[FRONT_LAT-1] || !full_i;
  assign in_ready_o = en;
  assign push_o     = vld_q[FRONT_LAT-1] && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[FRONT_LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      row_q <= row_i;
      col_q <= col_i;
    end
  end

  assign sx = $signed({3'b000, col_q, 1'b0}) - $signed({1'b0, w});
  assign sy = $signed({3'b000, row_q, 1'b0}) - $signed({1'b0, h});

  evm_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .neg_i (sx[17]),
    .num_i (div_num(abs18(sx), w)),
    .den_i (w),
    .quo_o (pos_o.nx)
  );

  evm_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .neg_i (sy[17]),
    .num_i (div_num(abs18(sy), h)),
    .den_i (h),
    .quo_o (pos_o.ny)
  );

endmodule

>>> hw/rtl/evm_fifo.sv
// Short queue of normalised positions between front and back end.
// Depends on evm_pkg.
module evm_fifo import evm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  pos_t    data_i,
  input  logic    pop_i,
  output pos_t    data_o,
  output q_stat_t stat_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  pos_t          buf_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(QUEUE_DEPTH));
  assign data_o       = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_q] <= data_i;
  end

endmodule

>>> hw/rtl/evm_back.sv
// Back end: ellipse distances, square roots, weight shaping and blend into the output word.
// Depends on evm_pkg, evm_div and evm_sqrt.
module evm_back import evm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        dual_i,
  input  logic [31:0] c1_i,
  input  logic [31:0] r1_i,
  input  logic [31:0] c2_i,
  input  logic [31:0] r2_i,
  input  logic [47:0] levels_i,
  input  logic        ok_i,
  input  q_stat_t     q_stat_i,
  input  pos_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [12:0] mask_o,
  output logic        res_valid_o
);

  logic [BACK_LAT-1:0] vld_q;
  logic                en;
  pos_t                pos_q;
  logic signed [QW-1:0] d_q [4];
  logic signed [QW-1:0] e_w [4];
  logic signed [QW-1:0] e_q [4];
  logic [30:0]          sq_q [4];
  logic [31:0]          rr_q [2];
  logic [ROOT_W-1:0]    rt_w [2];
  logic [ROOT_W-1:0]    rt_q [2];
  logic [12:0]          v_d, v_q;
  logic signed [30:0]   prod_q;
  logic [12:0]          mask_d, mask_q;
  logic                 resv_q;
  logic [31:0]          rad [4];
  logic signed [QW-1:0] light, dark, spot;

  assign light = levels_i[15:0];
  assign dark  = levels_i[31:16];
  assign spot  = levels_i[47:32];
  assign rad[0] = r1_i;
  assign rad[1] = {16'b0, r1_i[31:16]};
  assign rad[2] = r2_i;
  assign rad[3] = {16'b0, r2_i[31:16]};

  assign en          = !vld_q[BACK_LAT-1] || out_ready_i;
  assign pop_o       = en && !q_stat_i.empty;
  assign out_valid_o = vld_q[BACK_LAT-1];
  assign mask_o      = mask_q;
  assign res_valid_o = resv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[BACK_LAT-2:0], !q_stat_i.empty};
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    evm_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .neg_i (d_q[g][QW-1]),
      .num_i (div_num(abs18({{2{d_q[g][QW-1]}}, d_q[g]}), DEN_W'(rad[g][15:0]))),
      .den_i (DEN_W'(rad[g][15:0])),
      .quo_o (e_w[g])
    );
  end

  for (genvar g = 0; g < 2; g++) begin : g_sqrt
    evm_sqrt u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .val_i  (rr_q[g]),
      .root_o (rt_w[g])
    );
  end

  always_comb begin
    logic signed [19:0] a, thr, a2;
    thr = 20'sd4096 - 20'(spot);
    a2  = '0;
    if (!dual_i) begin
      a = 20'sd4096 - $signed({3'b000, 17'((17'(rt_q[0]) + 17'd1) >> 1)});
      if (a < 0) a = '0;
      if (a > thr) a = a + ((a - thr) >>> 1);
      if (a > 20'sd4096) a = 20'sd4096;
      v_d = a[12:0];
    end else begin
      a  = 20'sd4096 - $signed({4'b0000, rt_q[0]}) + 20'(spot);
      a2 = 20'sd4096 - $signed({4'b0000, rt_q[1]}) + 20'(spot);
      if (a < 0) a = '0;
      if (a > 20'sd4096) a = 20'sd4096;
      if (a2 < 0) a2 = '0;
      if (a2 > 20'sd4096) a2 = 20'sd4096;
      v_d = (a2 > a) ? a2[12:0] : a[12:0];
    end
  end

  always_comb begin
    logic signed [30:0] t;
    logic signed [19:0] s;
    t = prod_q + 31'sd2048;
    s = 20'(t >>> FRAC_BITS) + 20'(dark);
    if (s < 0) s = '0;
    if (s > 20'sd4096) s = 20'sd4096;
    mask_d = ok_i ? s[12:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q  <= head_i;
      d_q[0] <= sat_sub(pos_q.nx, c1_i[15:0]);
      d_q[1] <= sat_sub(pos_q.ny, c1_i[31:16]);
      d_q[2] <= sat_sub(pos_q.nx, c2_i[15:0]);
      d_q[3] <= sat_sub(pos_q.ny, c2_i[31:16]);
      for (int i = 0; i < 4; i++) begin
        e_q[i]  <= e_w[i];
        sq_q[i] <= 31'({{(32-QW){e_q[i][QW-1]}}, e_q[i]} * {{(32-QW){e_q[i][QW-1]}}, e_q[i]});
      end
      rr_q[0] <= 32'(sq_q[0]) + 32'(sq_q[1]);
      rr_q[1] <= 32'(sq_q[2]) + 32'(sq_q[3]);
      rt_q[0] <= rt_w[0];
      rt_q[1] <= rt_w[1];
      v_q     <= v_d;
      prod_q  <= ($signed({{15{light[QW-1]}}, light}) - $signed({{15{dark[QW-1]}}, dark}))
                 * $signed({18'b0, v_q});
      mask_q  <= mask_d;
      resv_q  <= ok_i;
    end
  end

endmodule

>>> tb/elliptical_vignette_mask_tb.sv
// Self-checking testbench for the elliptical vignette mask: drives pixel positions
// under many register settings and compares every mask word with a local predictor.
// Depends on evm_pkg and elliptical_vignette_mask.
`timescale 1ns / 100ps

module elliptical_vignette_mask_tb;
  import evm_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int SETTLE = 80;
  localparam int NUM_PHASES = 18;
  localparam longint MAX_DIM_TB = 16384;

  typedef struct packed {
    logic        ok;
    logic [12:0] mask;
  } mask_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // row[13:0], col[27:14], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // mask_value[12:0], zero pad
  logic        m_axis_tuser;        // valid_res

  logic        sh_dual;
  logic [30:0] sh_size;
  logic [31:0] sh_e1c, sh_e1r, sh_e2c, sh_e2r;
  logic [47:0] sh_levels;

  logic [31:0] pixel_queue[$];
  mask_word_t  masks_due[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          masks_seen = 0;
  int          hold_cycles = 0;
  bit          failed = 1'b0;

  elliptical_vignette_mask i_dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic longint q16(input logic [15:0] h);
    return longint'($signed(h));
  endfunction

  function automatic longint sat_q(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v < 0) return 0;
    if (v > ONE) return ONE;
    return v;
  endfunction

  function automatic longint div_nearest(input longint n, input longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint root_nearest(input longint v);
    longint r;
    r = longint'($sqrt(real'(v)));
    while (r * r > v) r--;
    while ((r + 1) * (r + 1) <= v) r++;
    if (v - r * r > r) r++;
    return r;
  endfunction

  function automatic longint ellipse_dist(input longint nx, input longint ny,
                                          input logic [31:0] c, input logic [31:0] r);
    longint dx, dy, ex, ey;
    dx = sat_q(nx - q16(c[15:0]));
    dy = sat_q(ny - q16(c[31:16]));
    ex = sat_q(div_nearest(dx * ONE, q16(r[15:0])));
    ey = sat_q(div_nearest(dy * ONE, q16(r[31:16])));
    return root_nearest(ex * ex + ey * ey);
  endfunction

  function automatic bit radii_pos(input logic [31:0] r);
    return q16(r[15:0]) > 0 && q16(r[31:16]) > 0;
  endfunction

  function automatic mask_word_t vignette_weight(input logic [31:0] px);
    mask_word_t res;
    longint row, col, w, h, light, dark, spot, nx, ny, v, r1, r2, thr, v1, v2;
    row = px[13:0];
    col = px[27:14];
    w = sh_size[15:0];
    h = sh_size[30:16];
    light = q16(sh_levels[15:0]);
    dark = q16(sh_levels[31:16]);
    spot = q16(sh_levels[47:32]);
    if (w > MAX_DIM_TB) w = MAX_DIM_TB;
    if (h > MAX_DIM_TB) h = MAX_DIM_TB;
    res = '0;
    if (w == 0 || h == 0 || !radii_pos(sh_e1r) || (sh_dual && !radii_pos(sh_e2r)))
      return res;
    nx = sat_q(div_nearest((2 * col - w) * ONE, w));
    ny = sat_q(div_nearest((2 * row - h) * ONE, h));
    if (!sh_dual) begin
      r1 = ellipse_dist(nx, ny, sh_e1c, sh_e1r);
      thr = ONE - spot;
      v = ONE - ((r1 + 1) >>> 1);
      if (v < 0) v = 0;
      if (v > thr) v = v + ((v - thr) >>> 1);
      if (v > ONE) v = ONE;
    end else begin
      r1 = ellipse_dist(nx, ny, sh_e1c, sh_e1r);
      r2 = ellipse_dist(nx, ny, sh_e2c, sh_e2r);
      v1 = clamp_unit(ONE - r1 + spot);
      v2 = clamp_unit(ONE - r2 + spot);
      v = v2 > v1 ? v2 : v1;
    end
    res.ok = 1'b1;
    res.mask = 13'(clamp_unit(dark + (((light - dark) * v + ONE / 2) >>> FRAC_BITS)));
    return res;
  endfunction

  // Driver: hold the word until taken, log the expected mask on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        masks_due.push_back(vignette_weight(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata <= pixel_queue.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each mask word, stall at random, one long hold mid-run.
  always @(posedge clk_i) begin
    mask_word_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        masks_seen++;
        if (masks_seen == 900) hold_cycles = 400;
        if (masks_due.size() == 0) begin
          $display("%0t: unexpected word mask=%0d ok=%0b", $time, m_axis_tdata[12:0],
                   m_axis_tuser);
          failed = 1'b1;
        end else begin
          want = masks_due.pop_front();
          if (m_axis_tdata !== {3'b000, want.mask} || m_axis_tuser !== want.ok) begin
            $display("%0t: expected mask=%0d ok=%0b, actual mask=%0d ok=%0b tdata=%h",
                     $time, want.mask, want.ok, m_axis_tdata[12:0], m_axis_tuser,
                     m_axis_tdata);
            failed = 1'b1;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_DUAL_MODE:  sh_dual = val[0];
      REG_IMAGE_SIZE: sh_size = val[30:0];
      REG_E1_CENTER:  sh_e1c = val[31:0];
      REG_E1_RADIUS:  sh_e1r = val[31:0];
      REG_E2_CENTER:  sh_e2c = val[31:0];
      REG_E2_RADIUS:  sh_e2r = val[31:0];
      REG_LEVELS:     sh_levels = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pixel_queue.size() != 0 || s_axis_tvalid || masks_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [15:0] near_unit();
    return 16'($urandom_range(8192) - 4096);
  endfunction

  function automatic logic [31:0] rand_radius();
    if ($urandom_range(9) == 0) return $urandom;
    return {16'($urandom_range(12288, 256)), 16'($urandom_range(12288, 256))};
  endfunction

  task automatic random_setup();
    int w, h;
    w = $urandom_range(3) == 0 ? $urandom_range(16384, 1) : $urandom_range(64, 1);
    h = $urandom_range(3) == 0 ? $urandom_range(16384, 1) : $urandom_range(64, 1);
    write_reg(REG_DUAL_MODE, 48'($urandom_range(1)));
    write_reg(REG_IMAGE_SIZE, $urandom_range(7) == 0 ? 48'($urandom) : 48'({h[15:0], w[15:0]}));
    write_reg(REG_E1_CENTER,
              $urandom_range(7) == 0 ? 48'($urandom) : 48'({near_unit(), near_unit()}));
    write_reg(REG_E1_RADIUS, 48'(rand_radius()));
    write_reg(REG_E2_CENTER,
              $urandom_range(7) == 0 ? 48'($urandom) : 48'({near_unit(), near_unit()}));
    write_reg(REG_E2_RADIUS, 48'(rand_radius()));
    if ($urandom_range(5) == 0)
      write_reg(REG_LEVELS, {16'($urandom), 16'($urandom), 16'($urandom)});
    else
      write_reg(REG_LEVELS, {near_unit(), 16'($urandom_range(2048)), 16'($urandom_range(4096, 2048))});
  endtask

  task automatic push_pixel(input int row, input int col);
    pixel_queue.push_back({4'b0000, 14'(col), 14'(row)});
  endtask

  initial begin
    int w, h;
    sh_dual = 1'b0;
    sh_size = 31'd67109888;
    sh_e1c = '0;
    sh_e1r = 32'd268439552;
    sh_e2c = '0;
    sh_e2r = 32'd268439552;
    sh_levels = 48'd4096;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      send_idle_pct = p < 6 ? 29 : (p < 12 ? 88 : 0);
      recv_idle_pct = p < 6 ? 88 : (p < 12 ? 29 : 0);
      case (p)
        0: ;
        1: begin
          write_reg(REG_DUAL_MODE, 48'd1);
          write_reg(REG_IMAGE_SIZE, 48'h0001_0001);
          write_reg(REG_LEVELS, 48'h7FFF_8000_7FFF);
        end
        2: begin
          write_reg(REG_DUAL_MODE, 48'd0);
          write_reg(REG_IMAGE_SIZE, 48'h7FFF_FFFF);
          write_reg(REG_E1_RADIUS, 48'h0001_0001);
          write_reg(REG_LEVELS, 48'h8000_7FFF_8000);
        end
        3: begin
          write_reg(REG_IMAGE_SIZE, 48'h4000_0000);
          write_reg(REG_E1_RADIUS, 48'h8000_7FFF);
        end
        4: begin
          write_reg(REG_DUAL_MODE, 48'd1);
          write_reg(REG_IMAGE_SIZE, 48'h0400_4000);
          write_reg(REG_E1_RADIUS, 48'h7FFF_1000);
          write_reg(REG_E2_CENTER, 48'h8000_7FFF);
          write_reg(REG_E2_RADIUS, 48'h1000_0000);
        end
        5: begin
          random_setup();
          write_reg(REG_SPARE, 48'hFFFF_FFFF_FFFF);
        end
        default: random_setup();
      endcase
      w = sh_size[15:0] > 16384 ? 16384 : sh_size[15:0];
      h = sh_size[30:16] > 16384 ? 16384 : sh_size[30:16];
      push_pixel(0, 0);
      push_pixel(16383, 16383);
      push_pixel(0, 16383);
      push_pixel(16383, 0);
      push_pixel(h / 2, w / 2);
      for (int i = 0; i < 105; i++) begin
        if ($urandom_range(4) == 0 || w == 0 || h == 0)
          push_pixel($urandom_range(16383), $urandom_range(16383));
        else
          push_pixel($urandom_range(h > 16384 ? 16383 : h - 1 + (h == 16384 ? 0 : 1)),
                     $urandom_range(w > 16384 ? 16383 : w - 1 + (w == 16384 ? 0 : 1)));
      end
    end
    drain();
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/evm_pkg.sv
hw/rtl/evm_div.sv
hw/rtl/evm_sqrt.sv
hw/rtl/evm_front.sv
hw/rtl/evm_fifo.sv
hw/rtl/evm_back.sv
hw/rtl/elliptical_vignette_mask.sv
tb/elliptical_vignette_mask_tb.sv
